FILE: sv/est_pkg.sv
// shared types and constants for the endpoint session table
// no dependencies; imported by est_cell and endpoint_session_table_unit
package est_pkg;

  localparam int SLOT_COUNT_DEF = 32;
  localparam int EP_W           = 32;
  localparam int PROTO_W        = 4;
  localparam int OP_W           = 3;
  localparam int STATUS_W       = 3;
  localparam int SLOT_W         = 5;
  localparam int FREE_W         = 6;
  localparam int PTC_W          = 5;
  localparam logic [PTC_W-1:0] PTC_RESET = 5'd5;

  typedef enum logic [OP_W-1:0] {
    OP_CREATE     = 3'd0,
    OP_FIND       = 3'd1,
    OP_CONNECT    = 3'd2,
    OP_DISCONNECT = 3'd3,
    OP_RELEASE    = 3'd4
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_BOUND     = 3'd2,
    ST_BAD_TYPE  = 3'd3,
    ST_FULL      = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

  // scan token that walks the cell row, one cell per cycle
  typedef struct packed {
    logic               active;
    logic [EP_W-1:0]    lep;
    logic               hit;
    logic [EP_W-1:0]    hit_remote;
    logic [PROTO_W-1:0] hit_proto;
    logic               hit_conn;
    logic               free_found;
  } scan_t;

  // full-entry write broadcast to the row, the cell at the write index takes it
  typedef struct packed {
    logic               en;
    logic               valid;
    logic [EP_W-1:0]    own_ep;
    logic [EP_W-1:0]    peer_ep;
    logic [PROTO_W-1:0] proto;
    logic               conn;
  } wr_t;

endpackage

FILE: sv/est_cell.sv
// one table slot: valid bit, endpoints, type and connected mark
// passes the scan token to its neighbor each cycle; uses est_pkg
module est_cell
  import est_pkg::*;
#(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF,
  parameter int IDX        = 0
) (
  input  logic                            clk,
  input  logic                            rst,
  input  scan_t                           tok_i,
  input  logic [$clog2(SLOT_COUNT)-1:0]   hit_idx_i,
  input  logic [$clog2(SLOT_COUNT)-1:0]   free_idx_i,
  input  logic [$clog2(SLOT_COUNT+1)-1:0] free_cnt_i,
  output scan_t                           tok_o,
  output logic [$clog2(SLOT_COUNT)-1:0]   hit_idx_o,
  output logic [$clog2(SLOT_COUNT)-1:0]   free_idx_o,
  output logic [$clog2(SLOT_COUNT+1)-1:0] free_cnt_o,
  input  wr_t                             wr,
  input  logic [$clog2(SLOT_COUNT)-1:0]   wr_idx
);

  localparam int IDX_W = $clog2(SLOT_COUNT);
  localparam int CNT_W = $clog2(SLOT_COUNT+1);
  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

  logic               valid;
  logic [EP_W-1:0]    own_ep;
  logic [EP_W-1:0]    peer_ep;
  logic [PROTO_W-1:0] proto;
  logic               conn;

  logic  match;
  logic  first_free;
  scan_t tok_next;

  // only the first valid match counts
  assign match      = valid && (own_ep == tok_i.lep) && !tok_i.hit;
  assign first_free = !valid && !tok_i.free_found;

  always_comb begin
    tok_next = tok_i;
    if (match) begin
      tok_next.hit        = 1'b1;
      tok_next.hit_remote = peer_ep;
      tok_next.hit_proto  = proto;
      tok_next.hit_conn   = conn;
    end
    if (first_free) begin
      tok_next.free_found = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_o.active <= 1'b0;
      valid        <= 1'b0;
    end else begin
      tok_o.active <= tok_i.active;
      if (wr.en && wr_idx == MY_IDX) begin
        valid <= wr.valid;
      end
    end
    tok_o.lep        <= tok_next.lep;
    tok_o.hit        <= tok_next.hit;
    tok_o.hit_remote <= tok_next.hit_remote;
    tok_o.hit_proto  <= tok_next.hit_proto;
    tok_o.hit_conn   <= tok_next.hit_conn;
    tok_o.free_found <= tok_next.free_found;
    hit_idx_o        <= match ? MY_IDX : hit_idx_i;
    free_idx_o       <= first_free ? MY_IDX : free_idx_i;
    free_cnt_o       <= free_cnt_i + CNT_W'(!valid);
    if (wr.en && wr_idx == MY_IDX) begin
      own_ep  <= wr.own_ep;
      peer_ep <= wr.peer_ep;
      proto   <= wr.proto;
      conn    <= wr.conn;
    end
  end

endmodule

FILE: sv/endpoint_session_table_unit.sv
// endpoint session table top level: request handshake, scan control,
// result register; depends on est_pkg and est_cell
//
// usage:
//   requests come in on in_valid/in_ready with op, own_ep, peer_ep and
//   proto_type; each request gives exactly one result on out_valid/out_ready.
//   the table is a row of SLOT_COUNT cells. a scan token enters cell 0 at the
//   accepting edge and moves one cell per cycle, picking up the first valid
//   match, the lowest free slot and the free count. after the last cell the
//   controller decides the outcome, writes the chosen slot and loads the
//   result register, which raises out_valid. one request is worked on at a
//   time; in_ready is high only while idle, so no new transaction is taken
//   while a scan or its decision is in progress, but a new transaction can
//   be taken while the last result waits.
//   if the receiver stalls, the finished scan holds until the result
//   register frees up; the table is written in that same cycle.
//   cfg_we writes protocol_type_count (reset 5), used from the next cycle.
//   reset (rst, synchronous) marks every slot free and drops any transaction
//   in flight; no clearing pass is needed.
module endpoint_session_table_unit
  import est_pkg::*;
#(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [OP_W-1:0]     op,
  input  logic [EP_W-1:0]     own_ep,
  input  logic [EP_W-1:0]     peer_ep,
  input  logic [PROTO_W-1:0]  proto_type,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [STATUS_W-1:0] status,
  output logic [SLOT_W-1:0]   slot,
  output logic [EP_W-1:0]     entry_remote_ep,
  output logic [PROTO_W-1:0]  entry_type,
  output logic                entry_connected,
  output logic [FREE_W-1:0]   free_slots,
  input  logic                cfg_we,
  input  logic [PTC_W-1:0]    cfg_wdata
);

  localparam int IDX_W = $clog2(SLOT_COUNT);
  localparam int CNT_W = $clog2(SLOT_COUNT+1);

  state_t state, state_next;
  logic [PTC_W-1:0] ptc;

  logic [OP_W-1:0]    req_op;
  logic [EP_W-1:0]    req_rep;
  logic [PROTO_W-1:0] req_typ;

  scan_t            tok  [SLOT_COUNT+1];
  logic [IDX_W-1:0] hidx [SLOT_COUNT+1];
  logic [IDX_W-1:0] fidx [SLOT_COUNT+1];
  logic [CNT_W-1:0] fcnt [SLOT_COUNT+1];
  logic [SLOT_COUNT-1:0] act_vec;

  scan_t            res_tok;
  logic [IDX_W-1:0] res_hidx;
  logic [IDX_W-1:0] res_fidx;
  logic [CNT_W-1:0] res_fcnt;

  logic in_acc;
  logic scan_end;
  logic do_load;
  logic chk_ok;

  status_t          o_st;
  logic [IDX_W-1:0] o_idx;
  logic [EP_W-1:0]  o_rem;
  logic [PROTO_W-1:0] o_typ;
  logic             o_conn;
  logic [CNT_W-1:0] o_free;
  wr_t              wr_dec;
  wr_t              wr;
  logic [IDX_W-1:0] wr_idx;

  assign in_ready = (state == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign scan_end = tok[SLOT_COUNT].active;
  assign do_load  = (state == S_DONE) && (!out_valid || out_ready);

  // seed token enters cell 0 on the accepting edge
  assign tok[0]  = '{active: in_acc, lep: own_ep, default: '0};
  assign hidx[0] = '0;
  assign fidx[0] = '0;
  assign fcnt[0] = '0;

  for (genvar g = 0; g < SLOT_COUNT; g++) begin : g_cell
    est_cell #(
      .SLOT_COUNT (SLOT_COUNT),
      .IDX        (g)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .tok_i      (tok[g]),
      .hit_idx_i  (hidx[g]),
      .free_idx_i (fidx[g]),
      .free_cnt_i (fcnt[g]),
      .tok_o      (tok[g+1]),
      .hit_idx_o  (hidx[g+1]),
      .free_idx_o (fidx[g+1]),
      .free_cnt_o (fcnt[g+1]),
      .wr         (wr),
      .wr_idx     (wr_idx)
    );
    assign act_vec[g] = tok[g+1].active;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ptc   <= PTC_RESET;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        ptc <= cfg_wdata;
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (in_acc) state_next = S_SCAN;
      S_SCAN:  if (scan_end) state_next = S_DONE;
      S_DONE:  if (do_load) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      req_op  <= op;
      req_rep <= peer_ep;
      req_typ <= proto_type;
    end
    if (state == S_SCAN && scan_end) begin
      res_tok  <= tok[SLOT_COUNT];
      res_hidx <= hidx[SLOT_COUNT];
      res_fidx <= fidx[SLOT_COUNT];
      res_fcnt <= fcnt[SLOT_COUNT];
    end
  end

  // a remote check looks only at the first match, it never goes further
  assign chk_ok = res_tok.hit && (req_rep == '0 || res_tok.hit_remote == req_rep);

  always_comb begin
    o_st   = ST_NOT_FOUND;
    o_idx  = '0;
    o_rem  = '0;
    o_typ  = '0;
    o_conn = 1'b0;
    o_free = res_fcnt;
    wr_dec = '0;
    wr_idx = res_hidx;
    case (req_op)
      OP_CREATE: begin
        if (res_tok.hit) begin
          o_st = ST_BOUND;
        end else if ({1'b0, req_typ} >= ptc) begin
          o_st = ST_BAD_TYPE;
        end else if (!res_tok.free_found) begin
          o_st = ST_FULL;
        end else begin
          o_st          = ST_OK;
          o_idx         = res_fidx;
          o_typ         = req_typ;
          o_free        = res_fcnt - CNT_W'(1);
          wr_idx        = res_fidx;
          wr_dec.en     = 1'b1;
          wr_dec.valid  = 1'b1;
          wr_dec.own_ep = res_tok.lep;
          wr_dec.proto  = req_typ;
        end
      end
      OP_FIND: begin
        if (chk_ok) begin
          o_st   = ST_OK;
          o_idx  = res_hidx;
          o_rem  = res_tok.hit_remote;
          o_typ  = res_tok.hit_proto;
          o_conn = res_tok.hit_conn;
        end
      end
      OP_CONNECT: begin
        if (chk_ok) begin
          o_st           = ST_OK;
          o_idx          = res_hidx;
          o_rem          = req_rep;
          o_typ          = res_tok.hit_proto;
          o_conn         = 1'b1;
          wr_dec.en      = 1'b1;
          wr_dec.valid   = 1'b1;
          wr_dec.own_ep  = res_tok.lep;
          wr_dec.peer_ep = req_rep;
          wr_dec.proto   = res_tok.hit_proto;
          wr_dec.conn    = 1'b1;
        end
      end
      OP_DISCONNECT: begin
        if (res_tok.hit) begin
          o_st          = ST_OK;
          o_idx         = res_hidx;
          o_typ         = res_tok.hit_proto;
          wr_dec.en     = 1'b1;
          wr_dec.valid  = 1'b1;
          wr_dec.own_ep = res_tok.lep;
          wr_dec.proto  = res_tok.hit_proto;
        end
      end
      OP_RELEASE: begin
        if (res_tok.hit) begin
          o_st      = ST_OK;
          o_idx     = res_hidx;
          o_free    = res_fcnt + CNT_W'(1);
          wr_dec.en = 1'b1;
        end
      end
      default: o_st = ST_NOT_FOUND;
    endcase
  end

  // table write lands in the same cycle the result is loaded
  always_comb begin
    wr    = wr_dec;
    wr.en = wr_dec.en && do_load;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (do_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_load) begin
      status          <= o_st;
      slot            <= SLOT_W'(o_idx);
      entry_remote_ep <= o_rem;
      entry_type      <= o_typ;
      entry_connected <= o_conn;
      free_slots      <= FREE_W'(o_free);
    end
  end

  a_one_token: assert property (@(posedge clk) disable iff (rst)
    $onehot0(act_vec))
    else $error("more than one scan token in the cell row");

  a_end_in_scan: assert property (@(posedge clk) disable iff (rst)
    scan_end |-> state == S_SCAN)
    else $error("scan token left the row outside a scan");

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> (state == S_SCAN) && tok[1].active)
    else $error("accepted transaction did not start a scan");

  a_write_on_load: assert property (@(posedge clk) disable iff (rst)
    wr.en |-> do_load && o_st == ST_OK)
    else $error("table written without a successful result");

endmodule
